// ----- rtl/core/acs_pkg.sv -----
// Shared types, constants and codes for the accumulator CPU step core.
// No dependencies; used by every module of the block by scoped names.
package acs_pkg;

  // Memory geometry
  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int WORD_W    = 16;
  localparam int PC_W      = 13;
  localparam int LA_W      = 12;

  // Stream word widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  // Status codes
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_BAD_IO  = 3'd2;
  localparam logic [2:0] ST_BAD_SH  = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;

  // Item kinds carried on in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // I/O subcodes
  localparam logic [3:0] IO_HEX_IN   = 4'd0;
  localparam logic [3:0] IO_CHAR_IN  = 4'd4;
  localparam logic [3:0] IO_HEX_OUT  = 4'd8;
  localparam logic [3:0] IO_CHAR_OUT = 4'd12;

  // Shift subcodes
  localparam logic [3:0] SH_LEFT  = 4'd0;
  localparam logic [3:0] SH_RIGHT = 4'd4;
  localparam logic [3:0] SH_ROTL  = 4'd8;
  localparam logic [3:0] SH_ROTR  = 4'd12;

  typedef enum logic [3:0] {
    OPC_HALT  = 4'd0,
    OPC_IO    = 4'd1,
    OPC_SHIFT = 4'd2,
    OPC_LOAD  = 4'd3,
    OPC_STORE = 4'd4,
    OPC_ADD   = 4'd5,
    OPC_SUB   = 4'd6,
    OPC_AND   = 4'd7,
    OPC_OR    = 4'd8,
    OPC_XOR   = 4'd9,
    OPC_NOT   = 4'd10,
    OPC_NOP   = 4'd11,
    OPC_JMP   = 4'd12,
    OPC_JMPE  = 4'd13,
    OPC_JMPL  = 4'd14,
    OPC_BRL   = 4'd15
  } opcode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_FETCH,
    S_DECODE,
    S_OPER,
    S_DONE
  } state_t;

  // Architectural update produced by one executed instruction
  typedef struct packed {
    logic [2:0]        status;
    logic [PC_W-1:0]   pc;
    logic [WORD_W-1:0] acc;
    logic              out_valid;
    logic              out_is_char;
    logic [WORD_W-1:0] out_value;
  } exec_t;

  // Opcodes that read an operand word from memory
  function automatic logic reads_operand(input logic [3:0] opc);
    reads_operand = (opc == OPC_LOAD) || (opc == OPC_ADD) || (opc == OPC_SUB) ||
                    (opc == OPC_AND) || (opc == OPC_OR) || (opc == OPC_XOR);
  endfunction

  // True where a 12-bit address falls inside the memory
  function automatic logic addr_in_range(input logic [LA_W-1:0] a);
    addr_in_range = PC_W'(a) < PC_W'(MEM_WORDS);
  endfunction

endpackage

// ----- rtl/core/acs_ram.sv -----
// Single-port program memory with registered read data (read-first).
// Depends on acs_pkg for depth and word width.
module acs_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [acs_pkg::ADDR_W-1:0] addr,
  input  logic [acs_pkg::WORD_W-1:0] wdata,
  output logic [acs_pkg::WORD_W-1:0] rdata
);

  logic [acs_pkg::WORD_W-1:0] mem [acs_pkg::MEM_WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/acs_exec.sv -----
// Instruction execute unit: computes the next pc, accumulator, status and output.
// Depends on acs_pkg for opcodes, subcodes and the exec_t result struct.
module acs_exec (
  input  logic [acs_pkg::WORD_W-1:0] ins_i,
  input  logic [acs_pkg::WORD_W-1:0] acc_i,
  input  logic [acs_pkg::PC_W-1:0]   pc_i,
  input  logic [acs_pkg::WORD_W-1:0] operand_i,
  input  logic [acs_pkg::WORD_W-1:0] in_value_i,
  output acs_pkg::exec_t             res_o
);

  logic [3:0]                 sub;
  logic [3:0]                 shamt;
  logic [acs_pkg::PC_W-1:0]   pc_inc;
  logic [acs_pkg::PC_W-1:0]   target;
  logic [2*acs_pkg::WORD_W-1:0] rot_l;
  logic [2*acs_pkg::WORD_W-1:0] rot_r;

  assign sub    = ins_i[11:8];
  assign shamt  = ins_i[3:0];
  assign pc_inc = pc_i + acs_pkg::PC_W'(1);
  assign target = acs_pkg::PC_W'(ins_i[acs_pkg::LA_W-1:0]);
  assign rot_l  = {acc_i, acc_i} << shamt;
  assign rot_r  = {acc_i, acc_i} >> shamt;

  // Decode and execute
  always_comb begin
    res_o             = '0;
    res_o.status      = acs_pkg::ST_RUN;
    res_o.pc          = pc_inc;
    res_o.acc         = acc_i;
    unique case (acs_pkg::opcode_t'(ins_i[15:12]))
      acs_pkg::OPC_HALT: begin
        res_o.status = acs_pkg::ST_HALT;
        res_o.pc     = pc_i;
      end
      acs_pkg::OPC_IO: begin
        unique case (sub)
          acs_pkg::IO_HEX_IN:  res_o.acc = in_value_i;
          acs_pkg::IO_CHAR_IN: res_o.acc = {8'h00, in_value_i[7:0]};
          acs_pkg::IO_HEX_OUT: begin
            res_o.out_valid = 1'b1;
            res_o.out_value = acc_i;
          end
          acs_pkg::IO_CHAR_OUT: begin
            res_o.out_valid   = 1'b1;
            res_o.out_is_char = 1'b1;
            res_o.out_value   = {8'h00, acc_i[7:0]};
          end
          default: begin
            res_o.status = acs_pkg::ST_BAD_IO;
            res_o.pc     = pc_i;
          end
        endcase
      end
      acs_pkg::OPC_SHIFT: begin
        unique case (sub)
          acs_pkg::SH_LEFT:  res_o.acc = acc_i << shamt;
          acs_pkg::SH_RIGHT: res_o.acc = acc_i >> shamt;
          acs_pkg::SH_ROTL:  res_o.acc = rot_l[2*acs_pkg::WORD_W-1:acs_pkg::WORD_W];
          acs_pkg::SH_ROTR:  res_o.acc = rot_r[acs_pkg::WORD_W-1:0];
          default: begin
            res_o.status = acs_pkg::ST_BAD_SH;
            res_o.pc     = pc_i;
          end
        endcase
      end
      acs_pkg::OPC_LOAD:  res_o.acc = operand_i;
      acs_pkg::OPC_STORE: res_o.acc = acc_i;
      acs_pkg::OPC_ADD:   res_o.acc = acc_i + operand_i;
      acs_pkg::OPC_SUB:   res_o.acc = acc_i - operand_i;
      acs_pkg::OPC_AND:   res_o.acc = acc_i & operand_i;
      acs_pkg::OPC_OR:    res_o.acc = acc_i | operand_i;
      acs_pkg::OPC_XOR:   res_o.acc = acc_i ^ operand_i;
      acs_pkg::OPC_NOT:   res_o.acc = ~acc_i;
      acs_pkg::OPC_NOP:   res_o.acc = acc_i;
      acs_pkg::OPC_JMP:   res_o.pc  = target;
      acs_pkg::OPC_JMPE: begin
        if (acc_i == '0) begin
          res_o.pc = target;
        end
      end
      acs_pkg::OPC_JMPL: begin
        if (acc_i[acs_pkg::WORD_W-1]) begin
          res_o.pc = target;
        end
      end
      acs_pkg::OPC_BRL: begin
        res_o.acc = acs_pkg::WORD_W'(pc_inc);
        res_o.pc  = target;
      end
    endcase
  end

endmodule

// ----- rtl/core/accumulator_cpu_step_core.sv -----
// Accumulator CPU step core: memory word writes and single-instruction steps.
// Items are taken one at a time: in_tready is high only while idle, after the result of
// the last item has been loaded into the result register. The pace is set by the single
// memory port (fetch, then operand read or store) and the result register.
// Reset (rst_n low, synchronous) clears acc, pc and status, then a pass over every
// address zeroes the memory; no word is accepted until it ends.
module accumulator_cpu_step_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // load_addr[11:0], load_word[27:12], in_value[43:28], zero pad [47:44]
  input  logic [acs_pkg::IN_DATA_W-1:0]  in_tdata,
  // op[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[2:0], out_value[18:3], pc_now[31:19], acc_now[47:32]
  output logic [acs_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_valid[0], out_is_char[1]
  output logic [acs_pkg::OUT_USER_W-1:0] out_tuser
);

  acs_pkg::state_t state_r, state_nxt;

  logic [acs_pkg::ADDR_W-1:0] clr_cnt_r;
  logic [acs_pkg::LA_W-1:0]   la_r;
  logic [acs_pkg::WORD_W-1:0] lw_r;
  logic [acs_pkg::WORD_W-1:0] iv_r;
  logic [acs_pkg::WORD_W-1:0] ins_r;
  logic                       opnd_ok_r;

  logic [acs_pkg::WORD_W-1:0] acc_r;
  logic [acs_pkg::PC_W-1:0]   pc_r;
  logic [2:0]                 status_r;
  logic                       ov_r;
  logic                       oc_r;
  logic [acs_pkg::WORD_W-1:0] oval_r;

  logic                              out_tvalid_r;
  logic [acs_pkg::OUT_DATA_W-1:0]    out_tdata_r;
  logic [acs_pkg::OUT_USER_W-1:0]    out_tuser_r;

  logic                       mem_we;
  logic [acs_pkg::ADDR_W-1:0] mem_addr;
  logic [acs_pkg::WORD_W-1:0] mem_wdata;
  logic [acs_pkg::WORD_W-1:0] mem_rdata;

  logic                       in_acc;
  logic                       pc_over;
  logic                       out_load;
  logic [acs_pkg::WORD_W-1:0] ex_ins;
  logic [acs_pkg::WORD_W-1:0] ex_opnd;
  acs_pkg::exec_t             ex_res;

  assign in_acc  = in_tvalid && in_tready;
  assign pc_over = pc_r >= acs_pkg::PC_W'(acs_pkg::MEM_WORDS);
  assign ex_ins  = (state_r == acs_pkg::S_DECODE) ? mem_rdata : ins_r;
  assign ex_opnd = opnd_ok_r ? mem_rdata : '0;

  acs_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  acs_exec u_exec (
    .ins_i      (ex_ins),
    .acc_i      (acc_r),
    .pc_i       (pc_r),
    .operand_i  (ex_opnd),
    .in_value_i (iv_r),
    .res_o      (ex_res)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acs_pkg::S_CLEAR: begin
        if (clr_cnt_r == acs_pkg::ADDR_W'(acs_pkg::MEM_WORDS - 1)) begin
          state_nxt = acs_pkg::S_IDLE;
        end
      end
      acs_pkg::S_IDLE: begin
        if (in_acc) begin
          priority if (in_tuser == acs_pkg::OP_WRITE) begin
            state_nxt = acs_pkg::S_WRITE;
          end else if (status_r != acs_pkg::ST_RUN || pc_over) begin
            state_nxt = acs_pkg::S_DONE;
          end else begin
            state_nxt = acs_pkg::S_FETCH;
          end
        end
      end
      acs_pkg::S_WRITE:  state_nxt = acs_pkg::S_DONE;
      acs_pkg::S_FETCH:  state_nxt = acs_pkg::S_DECODE;
      acs_pkg::S_DECODE: begin
        state_nxt = acs_pkg::reads_operand(mem_rdata[15:12]) ? acs_pkg::S_OPER
                                                            : acs_pkg::S_DONE;
      end
      acs_pkg::S_OPER:   state_nxt = acs_pkg::S_DONE;
      acs_pkg::S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = acs_pkg::S_IDLE;
        end
      end
      default: state_nxt = acs_pkg::S_IDLE;
    endcase
  end

  // Memory port and handshake control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      acs_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
      end
      acs_pkg::S_IDLE: in_tready = 1'b1;
      acs_pkg::S_WRITE: begin
        mem_we    = acs_pkg::addr_in_range(la_r);
        mem_addr  = la_r[acs_pkg::ADDR_W-1:0];
        mem_wdata = lw_r;
      end
      acs_pkg::S_FETCH: mem_addr = pc_r[acs_pkg::ADDR_W-1:0];
      acs_pkg::S_DECODE: begin
        mem_addr  = mem_rdata[acs_pkg::ADDR_W-1:0];
        mem_wdata = acc_r;
        mem_we    = (mem_rdata[15:12] == acs_pkg::OPC_STORE) &&
                    acs_pkg::addr_in_range(mem_rdata[acs_pkg::LA_W-1:0]);
      end
      acs_pkg::S_OPER: mem_addr = '0;
      acs_pkg::S_DONE: out_load = !out_tvalid_r || out_tready;
      default: mem_addr = '0;
    endcase
  end

  // State and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= acs_pkg::S_CLEAR;
      clr_cnt_r <= '0;
      acc_r     <= '0;
      pc_r      <= '0;
      status_r  <= acs_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
      if (state_r == acs_pkg::S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + acs_pkg::ADDR_W'(1);
      end
      // Flag a step that starts past the end of memory
      if (in_acc && in_tuser == acs_pkg::OP_STEP && status_r == acs_pkg::ST_RUN &&
          pc_over) begin
        status_r <= acs_pkg::ST_OVERRUN;
      end
      // Commit the executed instruction
      if ((state_r == acs_pkg::S_DECODE && !acs_pkg::reads_operand(mem_rdata[15:12])) ||
          state_r == acs_pkg::S_OPER) begin
        acc_r    <= ex_res.acc;
        pc_r     <= ex_res.pc;
        status_r <= ex_res.status;
      end
    end
  end

  // Item and step payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      la_r   <= in_tdata[11:0];
      lw_r   <= in_tdata[27:12];
      iv_r   <= in_tdata[43:28];
      ov_r   <= 1'b0;
      oc_r   <= 1'b0;
      oval_r <= '0;
    end
    if (state_r == acs_pkg::S_DECODE) begin
      ins_r     <= mem_rdata;
      opnd_ok_r <= acs_pkg::addr_in_range(mem_rdata[acs_pkg::LA_W-1:0]);
      if (!acs_pkg::reads_operand(mem_rdata[15:12])) begin
        ov_r   <= ex_res.out_valid;
        oc_r   <= ex_res.out_is_char;
        oval_r <= ex_res.out_value;
      end
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {acc_r, pc_r, oval_r, status_r};
      out_tuser_r <= {oc_r, ov_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- rtl/core/acs_checker.sv -----
// Port-level checker for the accumulator CPU step core, with its bind.
// Depends on acs_pkg for stream widths.
module acs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [acs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [acs_pkg::OUT_USER_W-1:0] out_tuser
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // One item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // Status code stays within its defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd4)
    else $error("status code out of range");

  // No output instruction: output value and kind are zero
  a_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tuser[1] && out_tdata[18:3] == 16'h0000)
    else $error("output fields set without an output instruction");

  // Char output carries only the low byte
  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && out_tdata[18:11] == 8'h00)
    else $error("char output with high byte set");

endmodule

bind accumulator_cpu_step_core acs_checker u_acs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for accumulator_cpu_step_core: streams memory word writes and instruction steps,
// predicts every result word with its own machine model. Depends on acs_pkg and the core only.
module tb_top;
  import acs_pkg::*;

  // One expected or observed result word, fields as the result stream carries them
  typedef struct packed {
    logic [2:0]        status;
    logic              out_valid;
    logic              out_is_char;
    logic [WORD_W-1:0] out_value;
    logic [PC_W-1:0]   pc_now;
    logic [WORD_W-1:0] acc_now;
  } step_result_t;

  // Machine model plus the queue of results still owed by the core
  class cpu_scoreboard;
    logic [WORD_W-1:0] words [MEM_WORDS];
    logic [WORD_W-1:0] acc;
    logic [PC_W-1:0]   pc;
    logic [2:0]        status;
    step_result_t      expected_q[$];
    int                errors;

    function new();
      int i;
      for (i = 0; i < MEM_WORDS; i++) words[i] = '0;
      acc = '0;
      pc = '0;
      status = ST_RUN;
      errors = 0;
    endfunction

    // Apply one accepted input word to the model and queue its result
    function void note_input(logic op, logic [LA_W-1:0] la, logic [WORD_W-1:0] lw,
                             logic [WORD_W-1:0] iv);
      step_result_t r;
      logic [WORD_W-1:0] ins;
      logic [WORD_W-1:0] operand;
      opcode_t opc;
      logic [3:0] sub;
      logic [3:0] shamt;
      logic [LA_W-1:0] a;
      logic [PC_W-1:0] nxt;
      r = '0;
      if (op == OP_WRITE) begin
        words[la] = lw;
      end else if (status == ST_RUN) begin
        if (pc >= PC_W'(MEM_WORDS)) begin
          status = ST_OVERRUN;
        end else begin
          ins = words[pc[ADDR_W-1:0]];
          opc = opcode_t'(ins[15:12]);
          sub = ins[11:8];
          shamt = ins[3:0];
          a = ins[11:0];
          operand = words[a];
          nxt = pc + 1'b1;
          case (opc)
            OPC_HALT: begin
              status = ST_HALT;
              nxt = pc;
            end
            OPC_IO: begin
              case (sub)
                IO_HEX_IN: acc = iv;
                IO_CHAR_IN: acc = {8'h00, iv[7:0]};
                IO_HEX_OUT: begin
                  r.out_valid = 1'b1;
                  r.out_value = acc;
                end
                IO_CHAR_OUT: begin
                  r.out_valid = 1'b1;
                  r.out_is_char = 1'b1;
                  r.out_value = {8'h00, acc[7:0]};
                end
                default: begin
                  status = ST_BAD_IO;
                  nxt = pc;
                end
              endcase
            end
            OPC_SHIFT: begin
              // zero fill for shifts; a rotate by zero leaves acc alone
              case (sub)
                SH_LEFT: acc = acc << shamt;
                SH_RIGHT: acc = acc >> shamt;
                SH_ROTL: acc = (acc << shamt) | (acc >> (5'd16 - shamt));
                SH_ROTR: acc = (acc >> shamt) | (acc << (5'd16 - shamt));
                default: begin
                  status = ST_BAD_SH;
                  nxt = pc;
                end
              endcase
            end
            OPC_LOAD: acc = operand;
            OPC_STORE: words[a] = acc;
            OPC_ADD: acc = acc + operand;
            OPC_SUB: acc = acc - operand;
            OPC_AND: acc = acc & operand;
            OPC_OR: acc = acc | operand;
            OPC_XOR: acc = acc ^ operand;
            OPC_NOT: acc = ~acc;
            OPC_NOP: ;
            OPC_JMP: nxt = PC_W'(a);
            OPC_JMPE: if (acc == '0) nxt = PC_W'(a);
            OPC_JMPL: if (acc[15]) nxt = PC_W'(a);
            default: begin
              acc = WORD_W'(nxt);
              nxt = PC_W'(a);
            end
          endcase
          pc = nxt;
        end
      end
      r.status = status;
      r.pc_now = pc;
      r.acc_now = acc;
      expected_q.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest expectation
    task check_result(step_result_t got);
      step_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with nothing pending: st=%0d pc=%0d acc=%h",
                         got.status, got.pc_now, got.acc_now));
      end else begin
        want = expected_q.pop_front();
        if (got !== want)
          report($sformatf({"got st=%0d ov=%0d ch=%0d val=%h pc=%0d acc=%h, ",
                            "want st=%0d ov=%0d ch=%0d val=%h pc=%0d acc=%h"},
                           got.status, got.out_valid, got.out_is_char, got.out_value,
                           got.pc_now, got.acc_now, want.status, want.out_valid,
                           want.out_is_char, want.out_value, want.pc_now, want.acc_now));
      end
    endtask

    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR %0t: %s", $time, msg);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  cpu_scoreboard sb = new();
  int items_sent = 0;
  int send_idle_pct = 0;
  int ready_stall_pct = 20;
  bit calm = 1'b0;
  bit held_once = 1'b0;

  accumulator_cpu_step_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // Sample both handshakes; check results before noting new input words
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_tvalid === 1'b1 && out_tready)
        sb.check_result({out_tdata[2:0], out_tuser[0], out_tuser[1], out_tdata[18:3],
                         out_tdata[31:19], out_tdata[47:32]});
      if (in_tvalid && in_tready === 1'b1)
        sb.note_input(in_tuser, in_tdata[11:0], in_tdata[27:12], in_tdata[43:28]);
    end
  end

  // Receiver: random stall bursts, one long hold-off, always ready near the end
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_tready = 1'b1;
      end else if (!held_once && items_sent >= 300) begin
        held_once = 1'b1;
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
        out_tready = 1'b1;
      end else if ($urandom_range(0, 99) < ready_stall_pct) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 3))
          0: ready_stall_pct = 0;
          1: ready_stall_pct = 10;
          2: ready_stall_pct = 30;
          default: ready_stall_pct = 50;
        endcase
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Mostly random, sometimes an extreme value
  function automatic logic [WORD_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return WORD_W'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'h00FF;
    endcase
  endfunction

  // True for an instruction that leaves the machine running
  function automatic bit runnable(logic [WORD_W-1:0] w);
    case (opcode_t'(w[15:12]))
      OPC_HALT: return 1'b0;
      OPC_IO, OPC_SHIFT: return w[9:8] == 2'b00;
      default: return 1'b1;
    endcase
  endfunction

  // Random runnable instruction; operands and targets lean toward the current region
  function automatic logic [WORD_W-1:0] rand_instr(int base);
    opcode_t opc;
    logic [LA_W-1:0] tail;
    opc = opcode_t'(4'($urandom_range(1, 15)));
    tail = LA_W'($urandom);
    case (opc)
      OPC_IO, OPC_SHIFT: tail[9:8] = 2'b00;
      OPC_LOAD, OPC_STORE, OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR:
        if ($urandom_range(0, 99) < 70) tail = LA_W'(base + 32 + $urandom_range(0, 15));
      OPC_JMP, OPC_JMPE, OPC_JMPL, OPC_BRL:
        if ($urandom_range(0, 99) < 75) tail = LA_W'(base + $urandom_range(0, 31));
      default: ;
    endcase
    return {opc, tail};
  endfunction

  // Advance to the next falling edge, maybe idling the input for a burst
  task automatic pause_in();
    int n;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      n = $urandom_range(1, 13);
      in_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Offer one word and hold it until accepted
  task automatic drive_word(logic op, logic [LA_W-1:0] la, logic [WORD_W-1:0] lw,
                            logic [WORD_W-1:0] iv);
    in_tuser = op;
    in_tdata = {4'h0, iv, lw, la};
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    items_sent++;
  endtask

  task automatic put_write(logic [LA_W-1:0] la, logic [WORD_W-1:0] lw);
    pause_in();
    drive_word(OP_WRITE, la, lw, pick_value());
  endtask

  task automatic put_step();
    pause_in();
    drive_word(OP_STEP, LA_W'($urandom), WORD_W'($urandom), pick_value());
  endtask

  // Step once, first patching the word at pc if it would stop the machine
  task automatic run_step(int base);
    logic [LA_W-1:0] slot;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] fix;
    opcode_t jop;
    bit need;
    pause_in();
    slot = sb.pc[ADDR_W-1:0];
    cur = sb.words[slot];
    if (sb.pc == PC_W'(MEM_WORDS - 1)) begin
      // top word must jump away, or pc would run off the end
      need = opcode_t'(cur[15:12]) != OPC_JMP && opcode_t'(cur[15:12]) != OPC_BRL;
      jop = $urandom_range(0, 1) ? OPC_JMP : OPC_BRL;
      fix = {jop, LA_W'(base + $urandom_range(0, 31))};
    end else begin
      need = !runnable(cur);
      fix = rand_instr(base);
    end
    if (need) begin
      drive_word(OP_WRITE, slot, fix, pick_value());
      pause_in();
    end
    drive_word(OP_STEP, LA_W'($urandom), WORD_W'($urandom), pick_value());
  endtask

  // Load a short program and data in a region, usually jump there, and run it
  task automatic run_phase();
    int base;
    int k;
    int n_prog;
    int n_data;
    int n_steps;
    case ($urandom_range(0, 9))
      0: base = 0;
      1: base = MEM_WORDS - 48;
      default: base = $urandom_range(0, MEM_WORDS - 48);
    endcase
    case ($urandom_range(0, 3))
      0, 1: send_idle_pct = 0;
      2: send_idle_pct = 10;
      default: send_idle_pct = 35;
    endcase
    n_prog = $urandom_range(4, 16);
    for (k = 0; k < n_prog; k++) put_write(LA_W'(base + k), rand_instr(base));
    n_data = $urandom_range(0, 4);
    for (k = 0; k < n_data; k++)
      put_write(LA_W'(base + 32 + $urandom_range(0, 15)), pick_value());
    // now and then skip the jump and keep running wherever pc is
    if ($urandom_range(0, 99) >= 15) begin
      pause_in();
      drive_word(OP_WRITE, sb.pc[ADDR_W-1:0], {OPC_JMP, LA_W'(base)}, pick_value());
    end
    n_steps = $urandom_range(8, 40);
    for (k = 0; k < n_steps; k++) begin
      if ($urandom_range(0, 99) < 12) put_write(LA_W'($urandom), WORD_W'($urandom));
      run_step(base);
    end
  endtask

  // Fixed program: every I/O subcode, rotates, memory ops and the address extremes
  task automatic run_directed();
    logic [WORD_W-1:0] prog [0:10];
    int i;
    prog[0] = {OPC_IO, IO_HEX_IN, 8'h00};
    prog[1] = {OPC_STORE, 12'hFFF};
    prog[2] = {OPC_IO, IO_CHAR_IN, 8'h00};
    prog[3] = {OPC_ADD, 12'hFFF};
    prog[4] = {OPC_IO, IO_HEX_OUT, 8'h00};
    prog[5] = {OPC_IO, IO_CHAR_OUT, 8'h00};
    prog[6] = {OPC_SHIFT, SH_ROTL, 8'h0F};
    prog[7] = {OPC_SHIFT, SH_ROTR, 8'h01};
    prog[8] = {OPC_SUB, 12'hFFF};
    prog[9] = {OPC_NOT, 12'h000};
    prog[10] = {OPC_JMPL, 12'hFFE};
    put_write(12'hFFF, 16'h0000);
    for (i = 0; i <= 10; i++) put_write(LA_W'(i), prog[i]);
    for (i = 0; i <= 10; i++) begin
      pause_in();
      drive_word(OP_STEP, 12'hFFF, 16'hFFFF,
                 (i == 0) ? 16'hFFFF : (i == 2) ? 16'hABCD : 16'h0000);
    end
  endtask

  // Drive the machine into one sticky stop, then show that it stays stopped
  task automatic run_terminal();
    logic [3:0] bad;
    opcode_t opc;
    int kind;
    int k;
    kind = $urandom_range(0, 3);
    bad = {2'($urandom), 2'($urandom_range(1, 3))};
    if (kind == 3) begin
      // run off the top of memory
      put_write(12'hFFF, {OPC_NOP, LA_W'($urandom)});
      pause_in();
      if (sb.pc[ADDR_W-1:0] != 12'hFFF)
        drive_word(OP_WRITE, sb.pc[ADDR_W-1:0], {OPC_JMP, 12'hFFF}, pick_value());
      else
        drive_word(OP_WRITE, 12'hFFF, {OPC_NOP, 12'h000}, pick_value());
      repeat (3) put_step();
    end else begin
      opc = (kind == 0) ? OPC_HALT : (kind == 1) ? OPC_IO : OPC_SHIFT;
      pause_in();
      if (kind == 0)
        drive_word(OP_WRITE, sb.pc[ADDR_W-1:0], {opc, LA_W'($urandom)}, pick_value());
      else
        drive_word(OP_WRITE, sb.pc[ADDR_W-1:0], {opc, bad, 8'($urandom)}, pick_value());
      put_step();
    end
    for (k = 0; k < 10; k++) begin
      if ($urandom_range(0, 1)) put_write(LA_W'($urandom), WORD_W'($urandom));
      else put_step();
    end
  endtask

  // Main sequence
  initial begin : stimulus
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    while (items_sent < 1550) run_phase();
    calm = 1'b1;
    while (items_sent < 1720) run_phase();
    run_terminal();
    @(negedge clk);
    in_tvalid = 1'b0;
    // drain, then give the core time to show any stray word
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
